// ===== design/ordered_list_append_delete_macros.svh =====
// Assertion helpers for the list datapath.
`ifndef ORDERED_LIST_APPEND_DELETE_MACROS_SVH
`define ORDERED_LIST_APPEND_DELETE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLAD_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OLAD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/olad_pkg.sv =====
`timescale 1ns / 1ps

package olad_pkg;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_DUMP,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_IDX,
      RD_NEXT,
      RD_AFTER
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       mem_we;
      logic       wr_shift;
      logic       inc_count;
      logic       dec_count;
      logic       idx_clr;
      logic       idx_inc;
      rd_sel_type rd_sel;
      logic       status_ld;
      logic [1:0] status_val;
      logic       emit;
      logic       emit_dump;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       full;
      logic       match;
      logic       idx_last;
      logic       idx_pen;
      logic       out_free;
   } sts_type;

endpackage

// ===== design/olad_ctrl.sv =====
`timescale 1ns / 1ps

module olad_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  olad_pkg::sts_type  sts,
   output olad_pkg::cmd_type  cmd
);

   olad_pkg::state_type state_ff;
   olad_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olad_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = olad_pkg::RD_IDX;
      req_tready = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         olad_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = olad_pkg::ST_DECODE;
            end
         end
         olad_pkg::ST_DECODE: begin
            cmd.status_ld = 1'b1;
            case (sts.op)
               olad_pkg::OP_APPEND: begin
                  if (sts.full) begin
                     cmd.status_val = olad_pkg::STATUS_FULL;
                  end else begin
                     cmd.status_val = olad_pkg::STATUS_OK;
                     cmd.mem_we     = 1'b1;
                     cmd.inc_count  = 1'b1;
                  end
                  state_in = olad_pkg::ST_RESULT;
               end
               olad_pkg::OP_DELETE: begin
                  if (sts.count_zero) begin
                     cmd.status_val = olad_pkg::STATUS_EMPTY;
                     state_in       = olad_pkg::ST_RESULT;
                  end else begin
                     cmd.status_ld = 1'b0;
                     cmd.idx_clr   = 1'b1;
                     cmd.rd_sel    = olad_pkg::RD_ZERO;
                     state_in      = olad_pkg::ST_SCAN;
                  end
               end
               olad_pkg::OP_DUMP: begin
                  if (sts.count_zero) begin
                     cmd.status_val = olad_pkg::STATUS_EMPTY;
                     state_in       = olad_pkg::ST_RESULT;
                  end else begin
                     cmd.status_ld = 1'b0;
                     cmd.idx_clr   = 1'b1;
                     cmd.rd_sel    = olad_pkg::RD_ZERO;
                     state_in      = olad_pkg::ST_DUMP;
                  end
               end
               default: begin
                  cmd.status_val = olad_pkg::STATUS_OK;
                  state_in       = olad_pkg::ST_RESULT;
               end
            endcase
         end
         olad_pkg::ST_SCAN: begin
            if (sts.match) begin
               if (sts.idx_last) begin
                  cmd.dec_count  = 1'b1;
                  cmd.status_ld  = 1'b1;
                  cmd.status_val = olad_pkg::STATUS_OK;
                  state_in       = olad_pkg::ST_RESULT;
               end else begin
                  cmd.rd_sel = olad_pkg::RD_NEXT;
                  state_in   = olad_pkg::ST_SHIFT;
               end
            end else if (sts.idx_last) begin
               cmd.status_ld  = 1'b1;
               cmd.status_val = olad_pkg::STATUS_NOT_FOUND;
               state_in       = olad_pkg::ST_RESULT;
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.rd_sel  = olad_pkg::RD_NEXT;
            end
         end
         olad_pkg::ST_SHIFT: begin
            cmd.mem_we   = 1'b1;
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            cmd.rd_sel   = olad_pkg::RD_AFTER;
            if (sts.idx_pen) begin
               cmd.dec_count  = 1'b1;
               cmd.status_ld  = 1'b1;
               cmd.status_val = olad_pkg::STATUS_OK;
               state_in       = olad_pkg::ST_RESULT;
            end
         end
         olad_pkg::ST_DUMP: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_dump = 1'b1;
               cmd.idx_inc   = 1'b1;
               cmd.rd_sel    = olad_pkg::RD_NEXT;
               if (sts.idx_last) begin
                  state_in = olad_pkg::ST_IDLE;
               end
            end
         end
         olad_pkg::ST_RESULT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = olad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olad_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/olad_datapath.sv =====
`timescale 1ns / 1ps
`include "ordered_list_append_delete_macros.svh"

module olad_datapath #(
   parameter int LIST_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_key,
   input  olad_pkg::cmd_type  cmd,
   output olad_pkg::sts_type  sts,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_key,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);

   logic signed [31:0] mem [LIST_DEPTH];
   logic signed [31:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   logic [1:0]         op_ff;
   logic signed [31:0] key_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [AW-1:0]      idx_ff;
   logic [1:0]         res_status_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic signed [31:0] rsp_key_ff;
   logic [4:0]         rsp_count_ff;
   logic               rsp_last_ff;

   logic [CW:0]        idx_p1;
   logic [CW:0]        idx_p2;
   logic [CW:0]        count_w;
   logic [CW+4:0]      count_ext;
   logic               out_free;

   assign idx_p1    = (CW + 1)'(idx_ff) + (CW + 1)'(1);
   assign idx_p2    = (CW + 1)'(idx_ff) + (CW + 1)'(2);
   assign count_w   = (CW + 1)'(count_ff);
   assign count_ext = (CW + 5)'(count_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.rd_sel)
         olad_pkg::RD_ZERO:  rd_addr = '0;
         olad_pkg::RD_IDX:   rd_addr = idx_ff;
         olad_pkg::RD_NEXT:  rd_addr = idx_p1[AW-1:0];
         olad_pkg::RD_AFTER: rd_addr = idx_p2[AW-1:0];
         default:            rd_addr = idx_ff;
      endcase
   end

   assign wr_addr = cmd.wr_shift ? idx_ff : count_ff[AW-1:0];
   assign wr_data = cmd.wr_shift ? rd_data_ff : key_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.inc_count) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_op;
         key_ff <= req_key;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_p1[AW-1:0];
      end
      if (cmd.status_ld) begin
         res_status_ff <= cmd.status_val;
      end
      if (cmd.emit) begin
         rsp_count_ff <= count_ext[4:0];
         if (cmd.emit_dump) begin
            rsp_status_ff <= olad_pkg::STATUS_OK;
            rsp_key_ff    <= rd_data_ff;
            rsp_last_ff   <= (idx_p1 == count_w);
         end else begin
            rsp_status_ff <= res_status_ff;
            rsp_key_ff    <= '0;
            rsp_last_ff   <= 1'b1;
         end
      end
   end

   assign sts.op         = op_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.full       = (count_ff == CW'(LIST_DEPTH));
   assign sts.match      = (rd_data_ff == key_ff);
   assign sts.idx_last   = (idx_p1 == count_w);
   assign sts.idx_pen    = (idx_p2 == count_w);
   assign sts.out_free   = out_free;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_key    = rsp_key_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

   `OLAD_ASSERT(a_emit_free, cmd.emit, out_free, "Result overwritten before it was taken.")
   `OLAD_ASSERT_NEXT(a_inc_count, cmd.inc_count,
      count_ff == $past(count_ff) + CW'(1), "Count did not step up after append.")
   `OLAD_ASSERT(a_dec_nonzero, cmd.dec_count, count_ff != '0, "Delete removed a key from an empty list.")
   `OLAD_ASSERT(a_count_bound, 1'b1, count_ff <= CW'(LIST_DEPTH), "Count exceeds the list depth.")

endmodule

// ===== design/ordered_list_append_delete.sv =====
`timescale 1ns / 1ps
// Append and unused operation codes go through the decode and result states and raise one word,
// and the next request is taken once the controller is back in idle.
// Delete scans and then closes the gap one entry per cycle through the single store port:
// its word follows the scan and shift states, and the next request waits until it is issued.
// Dump gives one key per cycle while each word is taken at once; a held response word stalls it.
// Reset clears the key count and the handshake state; stored keys are not cleared.

module ordered_list_append_delete #(
   parameter int LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // key_value [31:0]
   input  logic [1:0]  req_tuser,  // operation [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // item_key [31:0], entry_count [36:32], zero fill
   output logic [1:0]  rsp_tuser,  // status [1:0]
   output logic        rsp_tlast
);

   olad_pkg::cmd_type  cmd;
   olad_pkg::sts_type  sts;
   logic signed [31:0] rsp_key;
   logic [4:0]         rsp_count;

   olad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   olad_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_key    (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_key    (rsp_key),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_count, rsp_key};

endmodule
